// ===== src/line_editor_with_history_defines.svh =====
// Assertion macros for the line editor with history.
// Included by the top level; depends on nothing else.
`ifndef LINE_EDITOR_WITH_HISTORY_DEFINES_SVH
`define LINE_EDITOR_WITH_HISTORY_DEFINES_SVH

// Check that a condition implies a consequence on the same edge.
`define LEH_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define LEH_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/leh_pkg.sv =====
// Shared types and constants for the line editor with history.
// No dependencies.
package leh_pkg;
	localparam int LINE_SIZE_DEF     = 64;
	localparam int HISTORY_DEPTH_DEF = 16;
	localparam int ENTRY_SIZE_DEF    = 64;

	typedef enum logic [3:0] {
		OP_INSERT = 4'd0, OP_SUBMIT = 4'd1, OP_ABORT = 4'd2, OP_CTRL_D = 4'd3,
		OP_BACKSPACE = 4'd4, OP_DELETE = 4'd5, OP_LEFT = 4'd6, OP_RIGHT = 4'd7,
		OP_HOME = 4'd8, OP_END = 4'd9, OP_KILL = 4'd10, OP_DEL_WORD = 4'd11,
		OP_OLDER = 4'd12, OP_NEWER = 4'd13, OP_IGNORE = 4'd14, OP_HIST_ADD = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		ST_EDITING = 3'd0, ST_SUBMITTED = 3'd1, ST_ABORTED = 3'd2,
		ST_EOF = 3'd3, ST_HIST_ADDED = 3'd4, ST_HIST_SKIPPED = 3'd5
	} status_t;

	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TILDE = 8'd126;

	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [0:0] REG_HIST_EN  = 1'b1;
endpackage

// ===== src/leh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module leh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/line_editor_with_history.sv =====
// Line editor with history ring. One key event enters per beat on the slave stream; the
// block then works on it alone, stepping a sequencer over a line RAM (and, for history
// operations, a saved-edit RAM, a history RAM and a staging RAM) one character at a time
// through one shared read/compare/write path. Cursor moves, kill and status-only
// operations go straight to the response; insert, delete and backspace shift the
// characters one by one; delete-word scans back then shifts; history recall and saving
// copy one character at a time; committing a history line compares with the newest entry
// when the lengths match and copies unless it is equal. Submit streams the line out one
// beat per character, holding each beat until the master takes it.
// Every item yields one result beat with last set, except submit, which yields one beat
// per character (last on the final one) or a single beat for an empty line. No clearing
// pass is needed after reset. s_tready is high only while the block waits for an item and
// no result beat is pending.
module line_editor_with_history
	import leh_pkg::*;
#(
	parameter int LINE_SIZE     = leh_pkg::LINE_SIZE_DEF,
	parameter int HISTORY_DEPTH = leh_pkg::HISTORY_DEPTH_DEF,
	parameter int ENTRY_SIZE    = leh_pkg::ENTRY_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: tdata = {char_in[11:4], operation[3:0]}, tlast = last_in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tlast,
	// master stream: tdata = {cursor_pos[19:14], line_length[13:8], char_out[7:0]}
	// padded to 24 bits; tuser = status[2:0]; tlast = last_out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
`include "line_editor_with_history_defines.svh"

	localparam int LW = $clog2(LINE_SIZE);         // line index width
	localparam int LC = $clog2(LINE_SIZE + 1);     // line count width
	localparam int EW = $clog2(ENTRY_SIZE);
	localparam int EC = $clog2(ENTRY_SIZE + 1);
	localparam int HD = (HISTORY_DEPTH < 2) ? 2 : HISTORY_DEPTH;
	localparam int HW = $clog2(HD);
	localparam int HC = $clog2(HISTORY_DEPTH + 1);
	localparam int AW = HW + EW;
	localparam int XW = (LC > EC) ? LC : EC;       // shared counter width

	typedef enum logic [4:0] {
		S_IDLE, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR, S_DW_RD, S_DW_CHK,
		S_SUB_RD, S_SUB_OUT, S_SAVE_RD, S_SAVE_WR, S_LOAD_RD, S_LOAD_WR,
		S_CMP_RD, S_CMP_CHK, S_CPY_RD, S_CPY_WR, S_RESP
	} state_t;

	typedef enum logic [1:0] { SRC_SAVED, SRC_HIST } src_t;

	state_t state_q;
	src_t   src_q;

	logic [6:0]    cap_q;
	logic          hist_en_q;
	logic [LC-1:0] len_q, cur_q;
	logic          nav_q;
	logic [HW-1:0] nav_pos_q;
	logic [EC-1:0] saved_len_q;
	logic [HW-1:0] head_q;
	logic [HC-1:0] count_q;
	logic [EC-1:0] ent_len_q [HD];
	logic [EC-1:0] stg_len_q;
	logic          stg_over_q, stg_done_q;

	// working registers of the sequencer
	logic [XW-1:0] idx_q, lim_q, dst_q;
	logic [7:0]    ch_q;
	logic          dw_phase_q;
	logic [HW-1:0] ent_q;
	logic [2:0]    st_q;

	// output register
	logic          ov_q;
	logic [7:0]    o_ch_q;
	logic [5:0]    o_len_q, o_cur_q;
	logic [2:0]    o_st_q;
	logic          o_last_q;

	// RAM ports
	logic          ln_we, sv_we, hs_we, sg_we;
	logic [LW-1:0] ln_wa, ln_ra;
	logic [7:0]    ln_wd, ln_rd, sv_wd, sv_rd, hs_wd, hs_rd, sg_wd, sg_rd;
	logic [EW-1:0] sv_wa, sv_ra, sg_wa, sg_ra;
	logic [AW-1:0] hs_wa, hs_ra;

	leh_ram #(.WIDTH(8), .DEPTH(LINE_SIZE)) u_line (.clk, .we(ln_we), .waddr(ln_wa),
		.wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
	leh_ram #(.WIDTH(8), .DEPTH(ENTRY_SIZE)) u_saved (.clk, .we(sv_we), .waddr(sv_wa),
		.wdata(sv_wd), .raddr(sv_ra), .rdata(sv_rd));
	leh_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_hist (.clk, .we(hs_we), .waddr(hs_wa),
		.wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));
	leh_ram #(.WIDTH(8), .DEPTH(ENTRY_SIZE)) u_stage (.clk, .we(sg_we), .waddr(sg_wa),
		.wdata(sg_wd), .raddr(sg_ra), .rdata(sg_rd));

	// effective capacity minus one: most characters the line may hold
	logic [LC-1:0] cap_lim;
	always_comb begin
		priority if (cap_q == 7'd0)
			cap_lim = '0;
		else if (32'(cap_q) > LINE_SIZE)
			cap_lim = LC'(LINE_SIZE - 1);
		else
			cap_lim = LC'(cap_q - 7'd1);
	end

	logic [3:0] in_op;
	logic [7:0] in_ch;
	assign in_op = s_tdata[3:0];
	assign in_ch = s_tdata[11:4];

	assign s_tready = (state_q == S_IDLE) && !ov_q;
	logic take;
	assign take = s_tvalid && s_tready;

	// configuration
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr[2])
			REG_CAPACITY: prdata = {25'd0, cap_q};
			REG_HIST_EN:  prdata = {31'd0, hist_en_q};
			default:      prdata = '0;
		endcase
	end

	// history slot of entry n counted back from newest
	function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] head, input logic [HW-1:0] n);
		logic [HW:0] t;
		t = {1'b0, head} + (HW+1)'(HISTORY_DEPTH) - (HW+1)'(1) - {1'b0, n};
		if (t >= (HW+1)'(HISTORY_DEPTH))
			t = t - (HW+1)'(HISTORY_DEPTH);
		return t[HW-1:0];
	endfunction

	logic [HW-1:0] newest_slot;
	assign newest_slot = slot_of(head_q, '0);

	// RAM address and write steering from the sequencer state
	always_comb begin
		ln_we = 1'b0; ln_wa = idx_q[LW-1:0]; ln_wd = ch_q; ln_ra = idx_q[LW-1:0];
		sv_we = 1'b0; sv_wa = idx_q[EW-1:0]; sv_wd = ln_rd; sv_ra = idx_q[EW-1:0];
		hs_we = 1'b0; hs_wa = {head_q, idx_q[EW-1:0]}; hs_wd = sg_rd;
		hs_ra = {ent_q, idx_q[EW-1:0]};
		sg_we = 1'b0; sg_wa = stg_len_q[EW-1:0]; sg_wd = in_ch; sg_ra = idx_q[EW-1:0];
		unique case (state_q)
			S_IDLE: begin
				sg_we = take && (op_t'(in_op) == OP_HIST_ADD) && !stg_done_q
					&& (in_ch != 8'd0) && (stg_len_q < EC'(ENTRY_SIZE - 1));
			end
			S_INS_RD: ln_ra = idx_q[LW-1:0] - LW'(1);
			S_INS_WR: begin
				// shifted char from the left, or the new one at the cursor
				ln_we = 1'b1;
				ln_wd = (idx_q == XW'(cur_q)) ? ch_q : ln_rd;
			end
			S_DEL_RD: ln_ra = idx_q[LW-1:0];
			S_DEL_WR: begin
				ln_we = 1'b1; ln_wa = dst_q[LW-1:0]; ln_wd = ln_rd;
			end
			S_DW_RD:   ln_ra = idx_q[LW-1:0] - LW'(1);
			S_SAVE_WR: sv_we = 1'b1;
			S_LOAD_WR: begin
				ln_we = 1'b1;
				ln_wd = (src_q == SRC_SAVED) ? sv_rd : hs_rd;
			end
			S_CMP_RD: hs_ra = {newest_slot, idx_q[EW-1:0]};
			S_CPY_WR: hs_we = 1'b1;
			default: ;
		endcase
	end

	// entry length of the slot being read back, clamped to the line limit
	logic [XW-1:0] load_n;
	always_comb begin
		logic [EC-1:0] n;
		n = (src_q == SRC_SAVED) ? saved_len_q : ent_len_q[ent_q];
		load_n = (XW'(n) > XW'(cap_lim)) ? XW'(cap_lim) : XW'(n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; src_q <= SRC_SAVED;
			cap_q <= 7'd64; hist_en_q <= 1'b1;
			len_q <= '0; cur_q <= '0; nav_q <= 1'b0; nav_pos_q <= '0;
			saved_len_q <= '0; head_q <= '0; count_q <= '0;
			for (int i = 0; i < HD; i++) ent_len_q[i] <= '0;
			stg_len_q <= '0; stg_over_q <= 1'b0; stg_done_q <= 1'b0;
			idx_q <= '0; lim_q <= '0; dst_q <= '0; ch_q <= '0; dw_phase_q <= 1'b0;
			ent_q <= '0; st_q <= '0;
			ov_q <= 1'b0; o_ch_q <= '0; o_len_q <= '0; o_cur_q <= '0;
			o_st_q <= '0; o_last_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_CAPACITY: cap_q <= pwdata[6:0];
					REG_HIST_EN:  hist_en_q <= pwdata[0];
					default: ;
				endcase
			end
			// drop the result beat once taken
			if (ov_q && m_tready)
				ov_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (take) begin
					st_q <= ST_EDITING;
					ch_q <= in_ch;
					state_q <= S_RESP;
					unique case (op_t'(in_op))
						OP_INSERT: if (in_ch >= CHAR_SPACE && in_ch <= CHAR_TILDE
								&& len_q < cap_lim) begin
							// shift the tail right, from the end down to the cursor
							idx_q <= XW'(len_q);
							state_q <= (len_q == cur_q) ? S_INS_WR : S_INS_RD;
						end
						OP_SUBMIT: begin
							idx_q <= '0;
							state_q <= S_SUB_RD;
						end
						OP_ABORT: begin
							st_q <= ST_ABORTED;
							len_q <= '0; cur_q <= '0; nav_q <= 1'b0; nav_pos_q <= '0;
							saved_len_q <= '0;
						end
						OP_CTRL_D, OP_DELETE: begin
							if (op_t'(in_op) == OP_CTRL_D && len_q == '0) begin
								st_q <= ST_EOF;
								cur_q <= '0; nav_q <= 1'b0; nav_pos_q <= '0;
								saved_len_q <= '0;
							end else if (cur_q < len_q) begin
								dst_q <= XW'(cur_q); idx_q <= XW'(cur_q) + XW'(1);
								lim_q <= XW'(len_q);
								state_q <= S_DEL_RD;
							end
						end
						OP_BACKSPACE: if (cur_q != '0) begin
							dst_q <= XW'(cur_q) - XW'(1); idx_q <= XW'(cur_q);
							lim_q <= XW'(len_q);
							cur_q <= cur_q - LC'(1);
							state_q <= S_DEL_RD;
						end
						OP_LEFT:  if (cur_q != '0) cur_q <= cur_q - LC'(1);
						OP_RIGHT: if (cur_q < len_q) cur_q <= cur_q + LC'(1);
						OP_HOME:  cur_q <= '0;
						OP_END:   cur_q <= len_q;
						OP_KILL:  len_q <= cur_q;
						OP_DEL_WORD: begin
							// scan back over spaces, then over the word
							idx_q <= XW'(cur_q); lim_q <= XW'(len_q); dst_q <= XW'(cur_q);
							dw_phase_q <= 1'b0;
							if (cur_q != '0) state_q <= S_DW_RD;
						end
						OP_OLDER: if (hist_en_q && count_q != '0) begin
							if (!nav_q) begin
								// save the edit in progress first
								idx_q <= '0;
								lim_q <= (32'(len_q) > ENTRY_SIZE - 1) ?
									XW'(ENTRY_SIZE - 1) : XW'(len_q);
								state_q <= S_SAVE_RD;
							end else if (HC'(nav_pos_q) + HC'(1) < count_q) begin
								nav_pos_q <= nav_pos_q + HW'(1);
								ent_q <= slot_of(head_q, nav_pos_q + HW'(1));
								src_q <= SRC_HIST; idx_q <= '0;
								state_q <= S_LOAD_RD;
							end
						end
						OP_NEWER: if (hist_en_q && nav_q) begin
							idx_q <= '0;
							if (nav_pos_q == '0) begin
								nav_q <= 1'b0; src_q <= SRC_SAVED;
							end else begin
								nav_pos_q <= nav_pos_q - HW'(1);
								ent_q <= slot_of(head_q, nav_pos_q - HW'(1));
								src_q <= SRC_HIST;
							end
							state_q <= S_LOAD_RD;
						end
						OP_HIST_ADD: begin
							logic [EC-1:0] n;
							logic          ovr;
							n = stg_len_q; ovr = stg_over_q;
							if (!stg_done_q) begin
								if (in_ch == 8'd0) stg_done_q <= 1'b1;
								else if (stg_len_q < EC'(ENTRY_SIZE - 1))
									n = stg_len_q + EC'(1);
								else ovr = 1'b1;
							end
							stg_len_q <= n; stg_over_q <= ovr;
							if (s_tlast) begin
								idx_q <= '0; lim_q <= XW'(n);
								if (n == '0) begin
									st_q <= ST_HIST_SKIPPED;
									stg_len_q <= '0; stg_over_q <= 1'b0; stg_done_q <= 1'b0;
								end else if (count_q != '0 && !ovr
										&& ent_len_q[newest_slot] == n)
									state_q <= S_CMP_RD;
								else
									state_q <= S_CPY_RD;
							end
						end
						default: ;
					endcase
				end

				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					// write the shifted char (or the new one at the cursor)
					if (idx_q == XW'(cur_q)) begin
						len_q <= len_q + LC'(1); cur_q <= cur_q + LC'(1);
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q - XW'(1);
						state_q <= (idx_q - XW'(1) == XW'(cur_q)) ? S_INS_WR : S_INS_RD;
					end
				end

				S_DEL_RD: begin
					if (idx_q >= lim_q) begin
						len_q <= LC'(dst_q);
						state_q <= S_RESP;
					end else
						state_q <= S_DEL_WR;
				end
				S_DEL_WR: begin
					idx_q <= idx_q + XW'(1); dst_q <= dst_q + XW'(1);
					state_q <= S_DEL_RD;
				end

				S_DW_RD: state_q <= S_DW_CHK;
				S_DW_CHK: begin
					logic stop;
					stop = dw_phase_q ? (ln_rd == CHAR_SPACE) : 1'b0;
					if (!dw_phase_q && ln_rd != CHAR_SPACE) dw_phase_q <= 1'b1;
					if (stop) begin
						cur_q <= LC'(idx_q); idx_q <= dst_q; dst_q <= idx_q;
						state_q <= S_DEL_RD;
					end else if (idx_q == XW'(1)) begin
						cur_q <= '0; idx_q <= dst_q; dst_q <= '0;
						state_q <= S_DEL_RD;
					end else begin
						idx_q <= idx_q - XW'(1);
						state_q <= S_DW_RD;
					end
				end

				S_SUB_RD: begin
					if (len_q == '0) begin
						o_ch_q <= '0; o_len_q <= '0; o_cur_q <= '0;
						o_st_q <= ST_SUBMITTED; o_last_q <= 1'b1; ov_q <= 1'b1;
						cur_q <= '0; nav_q <= 1'b0; nav_pos_q <= '0; saved_len_q <= '0;
						state_q <= S_IDLE;
					end else if (!ov_q || m_tready)
						state_q <= S_SUB_OUT;
				end
				S_SUB_OUT: begin
					o_ch_q <= ln_rd; o_len_q <= 6'(len_q); o_cur_q <= '0;
					o_st_q <= ST_SUBMITTED; ov_q <= 1'b1;
					o_last_q <= (idx_q + XW'(1) == XW'(len_q));
					if (idx_q + XW'(1) == XW'(len_q)) begin
						len_q <= '0; cur_q <= '0; nav_q <= 1'b0; nav_pos_q <= '0;
						saved_len_q <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + XW'(1);
						state_q <= S_SUB_RD;
					end
				end

				S_SAVE_RD: begin
					if (idx_q >= lim_q) begin
						saved_len_q <= EC'(lim_q);
						if (HC'(1) <= count_q) begin
							nav_q <= 1'b1; nav_pos_q <= '0;
							ent_q <= newest_slot; src_q <= SRC_HIST; idx_q <= '0;
							state_q <= S_LOAD_RD;
						end else
							state_q <= S_RESP;
					end else
						state_q <= S_SAVE_WR;
				end
				S_SAVE_WR: begin
					idx_q <= idx_q + XW'(1);
					state_q <= S_SAVE_RD;
				end

				S_LOAD_RD: begin
					if (idx_q >= load_n) begin
						len_q <= LC'(load_n); cur_q <= LC'(load_n);
						state_q <= S_RESP;
					end else
						state_q <= S_LOAD_WR;
				end
				S_LOAD_WR: begin
					idx_q <= idx_q + XW'(1);
					state_q <= S_LOAD_RD;
				end

				S_CMP_RD: begin
					if (idx_q >= lim_q) begin
						// whole line matched the newest entry
						st_q <= ST_HIST_SKIPPED;
						stg_len_q <= '0; stg_over_q <= 1'b0; stg_done_q <= 1'b0;
						state_q <= S_RESP;
					end else
						state_q <= S_CMP_CHK;
				end
				S_CMP_CHK: begin
					if (hs_rd != sg_rd) begin
						idx_q <= '0;
						state_q <= S_CPY_RD;
					end else begin
						idx_q <= idx_q + XW'(1);
						state_q <= S_CMP_RD;
					end
				end

				S_CPY_RD: begin
					if (idx_q >= lim_q) begin
						ent_len_q[head_q] <= EC'(lim_q);
						head_q <= (32'(head_q) == HISTORY_DEPTH - 1) ? '0 : head_q + HW'(1);
						if (32'(count_q) < HISTORY_DEPTH) count_q <= count_q + HC'(1);
						st_q <= ST_HIST_ADDED;
						stg_len_q <= '0; stg_over_q <= 1'b0; stg_done_q <= 1'b0;
						state_q <= S_RESP;
					end else
						state_q <= S_CPY_WR;
				end
				S_CPY_WR: begin
					idx_q <= idx_q + XW'(1);
					state_q <= S_CPY_RD;
				end

				S_RESP: if (!ov_q || m_tready) begin
					o_ch_q <= '0; o_len_q <= 6'(len_q); o_cur_q <= 6'(cur_q);
					o_st_q <= st_q; o_last_q <= 1'b1; ov_q <= 1'b1;
					state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {4'd0, o_cur_q, o_len_q, o_ch_q};
	assign m_tuser  = o_st_q;
	assign m_tlast  = o_last_q;

	// a pending beat must hold until taken
	`LEH_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "beat dropped")
	// no item accepted while busy
	`LEH_ASSERT_IMP(a_busy, clk, arst_n, state_q != S_IDLE, !s_tready, "accepted while busy")
	// cursor never beyond the line while idle
	`LEH_ASSERT_IMP(a_cur, clk, arst_n, state_q == S_IDLE, cur_q <= len_q, "cursor past end")
endmodule

// ===== verif/line_editor_with_history_tb.sv =====
// Self-checking testbench for the line editor with history ring.
// Depends on leh_pkg and the line_editor_with_history top level; includes no files.
`timescale 1ns / 100ps

module line_editor_with_history_tb;
	import leh_pkg::*;

	localparam int LSZ = 64;
	localparam int HDEPTH = 16;
	localparam int ESZ = 64;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic       last;
	} key_t;

	typedef struct packed {
		status_t    st;
		logic [7:0] ch;
		logic [5:0] len;
		logic [5:0] cur;
		logic       last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	line_editor_with_history dut (.*);

	always #5 clk = ~clk;

	// Editor shadow state
	logic [6:0] sh_cap;
	logic       sh_hen;
	logic [7:0] sh_line [LSZ];
	int         sh_len, sh_cur;
	bit         sh_nav;
	int         sh_navpos;
	logic [7:0] sh_saved [ESZ];
	int         sh_saved_len;
	logic [7:0] sh_hist [HDEPTH][ESZ];
	int         sh_hlen [HDEPTH];
	int         sh_head, sh_count;
	logic [7:0] sh_stage [ESZ];
	int         sh_stage_len;
	bit         sh_stage_over, sh_stage_done;

	key_t  pending_keys [$];
	beat_t expected_beats [$];
	int    errors = 0;
	int    cycles = 0;
	int    hold_off = 0;
	int    burst_left = 0, gap_left = 0;

	function automatic int cap_eff();
		int c;
		c = sh_cap;
		if (c < 1) c = 1;
		if (c > LSZ) c = LSZ;
		return c;
	endfunction

	function automatic void clear_line();
		sh_len = 0; sh_cur = 0; sh_nav = 0; sh_navpos = 0; sh_saved_len = 0;
	endfunction

	function automatic void cut_range(int from, int upto);
		for (int i = from; i < sh_len - (upto - from); i++) sh_line[i] = sh_line[i + upto - from];
		sh_len -= upto - from;
	endfunction

	function automatic void recall_entry(int idx);
		int pos, n;
		if (idx >= sh_count) return;
		pos = (sh_head + 2 * HDEPTH - 1 - idx) % HDEPTH;
		n = sh_hlen[pos];
		if (n > cap_eff() - 1) n = cap_eff() - 1;
		for (int i = 0; i < n; i++) sh_line[i] = sh_hist[pos][i];
		sh_len = n; sh_cur = n;
	endfunction

	function automatic status_t commit_stage();
		int n, prev;
		bit same;
		n = sh_stage_len;
		if (n == 0) return ST_HIST_SKIPPED;
		if (sh_count > 0 && !sh_stage_over) begin
			prev = (sh_head + HDEPTH - 1) % HDEPTH;
			same = (sh_hlen[prev] == n);
			for (int i = 0; i < n; i++)
				if (sh_hist[prev][i] != sh_stage[i]) same = 0;
			if (same) return ST_HIST_SKIPPED;
		end
		for (int i = 0; i < n; i++) sh_hist[sh_head][i] = sh_stage[i];
		sh_hlen[sh_head] = n;
		sh_head = (sh_head + 1) % HDEPTH;
		if (sh_count < HDEPTH) sh_count++;
		return ST_HIST_ADDED;
	endfunction

	function automatic beat_t mk(status_t s, logic [7:0] c, int l, int cu, logic la);
		beat_t b;
		b.st = s; b.ch = c; b.len = l[5:0]; b.cur = cu[5:0]; b.last = la;
		return b;
	endfunction

	// Apply one key to the shadow state and queue its result beats
	function automatic void edit_line(key_t k);
		status_t st;
		int c, n;
		st = ST_EDITING;
		case (k.op)
			OP_INSERT: begin
				if (k.ch >= CHAR_SPACE && k.ch <= CHAR_TILDE && sh_len + 1 < cap_eff()) begin
					for (int i = sh_len; i > sh_cur; i--) sh_line[i] = sh_line[i - 1];
					sh_line[sh_cur] = k.ch;
					sh_len++; sh_cur++;
				end
			end
			OP_SUBMIT: begin
				if (sh_len == 0) expected_beats.push_back(mk(ST_SUBMITTED, 8'd0, 0, 0, 1'b1));
				for (int i = 0; i < sh_len; i++)
					expected_beats.push_back(mk(ST_SUBMITTED, sh_line[i], sh_len, 0,
						i + 1 == sh_len));
				clear_line();
				return;
			end
			OP_ABORT: begin
				clear_line(); st = ST_ABORTED;
			end
			OP_CTRL_D: begin
				if (sh_len == 0) begin
					clear_line(); st = ST_EOF;
				end else if (sh_cur < sh_len) cut_range(sh_cur, sh_cur + 1);
			end
			OP_BACKSPACE: begin
				if (sh_cur > 0) begin
					cut_range(sh_cur - 1, sh_cur); sh_cur--;
				end
			end
			OP_DELETE: if (sh_cur < sh_len) cut_range(sh_cur, sh_cur + 1);
			OP_LEFT: if (sh_cur > 0) sh_cur--;
			OP_RIGHT: if (sh_cur < sh_len) sh_cur++;
			OP_HOME: sh_cur = 0;
			OP_END: sh_cur = sh_len;
			OP_KILL: sh_len = sh_cur;
			OP_DEL_WORD: begin
				c = sh_cur;
				while (c > 0 && sh_line[c - 1] == CHAR_SPACE) c--;
				while (c > 0 && sh_line[c - 1] != CHAR_SPACE) c--;
				cut_range(c, sh_cur);
				sh_cur = c;
			end
			OP_OLDER: begin
				if (sh_hen && sh_count > 0) begin
					if (!sh_nav) begin
						n = (sh_len > ESZ - 1) ? ESZ - 1 : sh_len;
						for (int i = 0; i < n; i++) sh_saved[i] = sh_line[i];
						sh_saved_len = n;
					end
					c = sh_nav ? sh_navpos + 1 : 0;
					if (c < sh_count) begin
						sh_nav = 1; sh_navpos = c; recall_entry(c);
					end
				end
			end
			OP_NEWER: begin
				if (sh_hen && sh_nav) begin
					if (sh_navpos == 0) begin
						sh_nav = 0;
						n = sh_saved_len;
						if (n > cap_eff() - 1) n = cap_eff() - 1;
						for (int i = 0; i < n; i++) sh_line[i] = sh_saved[i];
						sh_len = n; sh_cur = n;
					end else begin
						sh_navpos--; recall_entry(sh_navpos);
					end
				end
			end
			OP_HIST_ADD: begin
				if (!sh_stage_done) begin
					if (k.ch == 8'd0) sh_stage_done = 1;
					else if (sh_stage_len < ESZ - 1) sh_stage[sh_stage_len++] = k.ch;
					else sh_stage_over = 1;
				end
				if (k.last) begin
					st = commit_stage();
					sh_stage_len = 0; sh_stage_over = 0; sh_stage_done = 0;
				end
			end
			default: ;
		endcase
		expected_beats.push_back(mk(st, 8'd0, sh_len, sh_cur, 1'b1));
	endfunction

	// Driver: bursts with random gaps; hold valid until the beat is taken
	always @(posedge clk) begin
		key_t k;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				void'(pending_keys.pop_front());
				edit_line({op_t'(s_tdata[3:0]), s_tdata[11:4], s_tlast});
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered beat
			end else if (pending_keys.size() > (s_tvalid && s_tready ? 0 : 0) &&
					gap_left == 0 && pending_keys.size() != 0) begin
				k = pending_keys[0];
				s_tvalid <= 1'b1;
				s_tdata <= {4'd0, k.ch, k.op};
				s_tlast <= k.last;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
				end else if (burst_left == 1) begin
					burst_left <= 0;
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end else burst_left <= burst_left - 1;
			end else begin
				s_tvalid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end
		end
	end

	// Note: the driver pops the key it handed over once the handshake completes,
	// so the front of the queue is always the beat on the bus.

	// Monitor: compare each result beat against the oldest expectation
	always @(posedge clk) begin
		beat_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = mk(status_t'(m_tuser), m_tdata[7:0], m_tdata[13:8], m_tdata[19:14],
					m_tlast);
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, got);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (got.st != want.st)
						$display("%0t: status exp %0d got %0d", $time, want.st, got.st);
					if (got.ch != want.ch)
						$display("%0t: char exp %0d got %0d", $time, want.ch, got.ch);
					if (got.len != want.len)
						$display("%0t: length exp %0d got %0d", $time, want.len, got.len);
					if (got.cur != want.cur)
						$display("%0t: cursor exp %0d got %0d", $time, want.cur, got.cur);
					if (got.last != want.last)
						$display("%0t: last exp %0d got %0d", $time, want.last, got.last);
					if (got != want) errors++;
				end
			end
			// receiver stall pattern, with a long hold-off when asked
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(0, 3) != 0) || cycles[9];
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Write a register while idle and mirror it in the shadow
	task automatic set_reg(logic [0:0] idx, logic [31:0] v);
		while (pending_keys.size() != 0 || s_tvalid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		apb_write({idx, 2'b00}, v);
		if (idx == REG_CAPACITY) sh_cap = v[6:0];
		else sh_hen = v[0];
	endtask

	function automatic void push_key(op_t o, logic [7:0] c, logic l);
		key_t k;
		k.op = o; k.ch = c; k.last = l;
		pending_keys.push_back(k);
	endfunction

	function automatic logic [7:0] rand_print();
		return ($urandom_range(0, 4) == 0) ? CHAR_SPACE : 8'($urandom_range(33, 126));
	endfunction

	// Stream a history line; mostly clean, sometimes with a terminator or overlong
	function automatic void add_history_line(int n);
		for (int i = 0; i < n; i++) begin
			logic [7:0] c;
			c = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			push_key(OP_HIST_ADD, c, i == n - 1);
		end
	endfunction

	function automatic void random_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) push_key(OP_INSERT, ($urandom_range(0, 9) == 0) ?
			8'($urandom_range(0, 255)) : rand_print(), 1'($urandom));
		else if (r < 45) push_key(OP_SUBMIT, 8'($urandom), 1'($urandom));
		else if (r < 50) add_history_line($urandom_range(1, 6));
		else push_key(op_t'($urandom_range(2, 14)), 8'($urandom), 1'($urandom));
	endfunction

	initial begin
		int phase_items;
		for (int i = 0; i < HDEPTH; i++) sh_hlen[i] = 0;
		for (int i = 0; i < LSZ; i++) sh_line[i] = 8'd0;
		sh_cap = 7'd64; sh_hen = 1'b1;
		clear_line();
		sh_head = 0; sh_count = 0; sh_stage_len = 0; sh_stage_over = 0; sh_stage_done = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every operation and edge case
		push_key(OP_CTRL_D, 8'd0, 1'b0);         // end of input on empty line
		push_key(OP_SUBMIT, 8'd0, 1'b0);         // empty submit
		push_key(OP_INSERT, 8'd31, 1'b0);        // outside printable range
		push_key(OP_INSERT, 8'd127, 1'b0);
		push_key(OP_INSERT, 8'd255, 1'b1);
		push_key(OP_INSERT, CHAR_SPACE, 1'b0);
		push_key(OP_INSERT, CHAR_TILDE, 1'b0);
		push_key(OP_INSERT, 8'h41, 1'b0);
		push_key(OP_OLDER, 8'd0, 1'b0);          // empty history
		push_key(OP_HOME, 8'd0, 1'b0);
		push_key(OP_CTRL_D, 8'd0, 1'b0);         // deletes at cursor
		push_key(OP_RIGHT, 8'd0, 1'b0);
		push_key(OP_LEFT, 8'd0, 1'b0);
		push_key(OP_END, 8'd0, 1'b0);
		push_key(OP_DEL_WORD, 8'd0, 1'b0);
		push_key(OP_BACKSPACE, 8'd0, 1'b0);
		push_key(OP_DELETE, 8'd0, 1'b0);
		push_key(OP_KILL, 8'd0, 1'b0);
		push_key(OP_IGNORE, 8'hff, 1'b1);
		push_key(OP_HIST_ADD, 8'd0, 1'b1);       // empty line: skipped
		push_key(OP_HIST_ADD, 8'h61, 1'b1);
		push_key(OP_HIST_ADD, 8'h61, 1'b1);      // duplicate: skipped
		push_key(OP_NEWER, 8'd0, 1'b0);          // not navigating
		push_key(OP_OLDER, 8'd0, 1'b0);
		push_key(OP_NEWER, 8'd0, 1'b0);
		push_key(OP_ABORT, 8'd0, 1'b0);

		// Long receiver hold-off while a long submit and more keys queue up
		for (int i = 0; i < 12; i++) push_key(OP_INSERT, rand_print(), 1'b0);
		push_key(OP_SUBMIT, 8'd0, 1'b0);
		for (int i = 0; i < 6; i++) push_key(OP_LEFT, 8'd0, 1'b0);
		hold_off = 3000;

		// Full-length overlong history line, then a full line
		set_reg(REG_CAPACITY, 32'd64);
		add_history_line(65);
		for (int i = 0; i < 64; i++) push_key(OP_INSERT, rand_print(), 1'b0);
		push_key(OP_OLDER, 8'd0, 1'b0);
		push_key(OP_NEWER, 8'd0, 1'b0);
		push_key(OP_SUBMIT, 8'd0, 1'b0);

		// Random phases across capacity and history settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_reg(REG_CAPACITY, 32'd0);
				1: set_reg(REG_CAPACITY, 32'd1);
				2: set_reg(REG_CAPACITY, 32'd127);
				3: set_reg(REG_HIST_EN, 32'd0);
				4: set_reg(REG_CAPACITY, 32'd8);
				default: set_reg(REG_HIST_EN, 32'd1);
			endcase
			phase_items = 0;
			while (phase_items < 8) begin
				random_key();
				phase_items++;
			end
		end

		while (pending_keys.size() != 0 || s_tvalid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/leh_pkg.sv
src/leh_ram.sv
src/line_editor_with_history.sv
verif/line_editor_with_history_tb.sv
